FILE: hw/rtl/assert_macros.svh
// ---------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion helpers for the RTL.
// ---------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property checked on every rising edge outside reset
`define ASSERT_PROP(label, clk, rst, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// expression must never be true outside reset
`define ASSERT_NEVER(label, clk, rst, expr, msg) \
  `ASSERT_PROP(label, clk, rst, !(expr), msg)

`endif

FILE: hw/rtl/b64c_pkg.sv
// ---------------------------------------------------------------------------
// b64c_pkg
// Types, constants and alphabet functions for the base64url codec.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package b64c_pkg;

  localparam int QUEUE_DEPTH = 2;
  localparam int QPTR_W      = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

  localparam logic [7:0] CHR_UPPER_A = 8'h41;
  localparam logic [7:0] CHR_UPPER_Z = 8'h5a;
  localparam logic [7:0] CHR_LOWER_A = 8'h61;
  localparam logic [7:0] CHR_LOWER_Z = 8'h7a;
  localparam logic [7:0] CHR_DIGIT_0 = 8'h30;
  localparam logic [7:0] CHR_DIGIT_9 = 8'h39;
  localparam logic [7:0] CHR_DASH    = 8'h2d;
  localparam logic [7:0] CHR_USCORE  = 8'h5f;
  localparam logic [7:0] CHR_PAD     = 8'h3d;

  // char_to_sextet returns this for the pad character
  localparam logic [6:0] SEXTET_PAD  = 7'd64;
  localparam logic [2:0] PAD_MAX     = 3'd7;

  localparam logic DIR_ENCODE = 1'b0;
  localparam logic DIR_DECODE = 1'b1;

  typedef enum logic [1:0] {
    JOB_ENC  = 2'd0,  // four characters from a gathered group
    JOB_DEC  = 2'd1,  // one to three decoded bytes
    JOB_STAT = 2'd2   // status-only result
  } job_kind_t;

  typedef struct packed {
    job_kind_t   kind;
    logic [23:0] bits;
    logic [1:0]  cnt;     // enc: bytes gathered, dec: bytes to send
    logic        last;
    logic        status;
  } job_t;

  function automatic logic [7:0] sextet_to_char(input logic [5:0] v);
    logic [7:0] w;
    logic [7:0] ch;
    w = {2'b00, v};
    if (w < 8'd26) begin
      ch = CHR_UPPER_A + w;
    end else if (w < 8'd52) begin
      ch = CHR_LOWER_A + w - 8'd26;
    end else if (w < 8'd62) begin
      ch = CHR_DIGIT_0 + w - 8'd52;
    end else if (w == 8'd62) begin
      ch = CHR_DASH;
    end else begin
      ch = CHR_USCORE;
    end
    return ch;
  endfunction

  function automatic logic [6:0] char_to_sextet(input logic [7:0] c);
    logic [7:0] v;
    v = 8'd0;
    if (c >= CHR_UPPER_A && c <= CHR_UPPER_Z) begin
      v = c - CHR_UPPER_A;
    end else if (c >= CHR_LOWER_A && c <= CHR_LOWER_Z) begin
      v = c - CHR_LOWER_A + 8'd26;
    end else if (c >= CHR_DIGIT_0 && c <= CHR_DIGIT_9) begin
      v = c - CHR_DIGIT_0 + 8'd52;
    end else if (c == CHR_DASH) begin
      v = 8'd62;
    end else if (c == CHR_USCORE) begin
      v = 8'd63;
    end else if (c == CHR_PAD) begin
      v = {1'b0, SEXTET_PAD};
    end
    return v[6:0];
  endfunction

endpackage

`default_nettype wire

FILE: hw/rtl/base64url_codec.sv
// ---------------------------------------------------------------------------
// base64url_codec
// Streaming base64url encoder/decoder with '=' padding.
// ---------------------------------------------------------------------------
// The first result of a group goes through the job queue, then the output register.
// One input per cycle while the queue is not full, one result per cycle while
// the sink is ready; encoding is bound by the result port at four characters
// per three input bytes. A 2-entry queue lets input and output stall independently.
// Reset (rst, synchronous): direction = encode, group, queue and output empty.
`timescale 1ns / 1ps
`default_nettype none

module base64url_codec (
  input  wire logic       clk,
  input  wire logic       rst,
  input  wire logic       s_tvalid,
  output logic            s_tready,
  input  wire logic [7:0] s_tdata,   // [7:0] in_byte
  input  wire logic       s_tlast,   // in_last
  output logic            m_tvalid,
  input  wire logic       m_tready,
  output logic [7:0]      m_tdata,   // [7:0] out_byte
  output logic            m_tlast,   // out_last
  output logic [1:0]      m_tuser,   // [0] byte_valid, [1] status
  input  wire logic       cfg_valid,
  output logic            cfg_ready,
  input  wire logic       cfg_data   // direction
);
  import b64c_pkg::*;

  logic q_full, q_push, q_pop, q_valid;
  job_t push_job, head_job;

  b64c_front u_front (
    .clk       (clk),
    .rst       (rst),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .s_tdata   (s_tdata),
    .s_tlast   (s_tlast),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_data  (cfg_data),
    .q_full    (q_full),
    .q_push    (q_push),
    .q_job     (push_job)
  );

  b64c_queue u_queue (
    .clk        (clk),
    .rst        (rst),
    .push       (q_push),
    .push_job   (push_job),
    .full       (q_full),
    .pop        (q_pop),
    .head_valid (q_valid),
    .head_job   (head_job)
  );

  b64c_back u_back (
    .clk      (clk),
    .rst      (rst),
    .q_valid  (q_valid),
    .q_job    (head_job),
    .q_pop    (q_pop),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tlast  (m_tlast),
    .m_tuser  (m_tuser)
  );

endmodule

`default_nettype wire

FILE: hw/rtl/b64c_front.sv
// ---------------------------------------------------------------------------
// b64c_front
// Accepts input items, gathers groups and queues output jobs.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none
`include "assert_macros.svh"

module b64c_front (
  input  wire logic            clk,
  input  wire logic            rst,
  input  wire logic            s_tvalid,
  output logic                 s_tready,
  input  wire logic [7:0]      s_tdata,   // [7:0] in_byte
  input  wire logic            s_tlast,
  input  wire logic            cfg_valid,
  output logic                 cfg_ready,
  input  wire logic            cfg_data,
  input  wire logic            q_full,
  output logic                 q_push,
  output b64c_pkg::job_t       q_job
);
  import b64c_pkg::*;

  logic        direction;
  logic [23:0] group_bits, group_bits_next;
  logic [1:0]  group_count, group_count_next;
  logic [2:0]  pad_count, pad_count_next;

  logic        accept;
  logic [1:0]  enc_cnt, enc_cnt_new;
  logic [23:0] enc_bits, dec_bits;
  logic [6:0]  sx7;
  logic        is_pad;
  logic [5:0]  sx6;
  logic [2:0]  pad_new;
  logic [1:0]  nbytes;

  assign s_tready  = !q_full;
  assign cfg_ready = 1'b1;
  assign accept    = s_tvalid && s_tready;

  always_comb begin
    enc_cnt     = (group_count == 2'd3) ? 2'd2 : group_count;
    enc_cnt_new = enc_cnt + 2'd1;
    case (enc_cnt)
      2'd0:    enc_bits = group_bits | {s_tdata, 16'd0};
      2'd1:    enc_bits = group_bits | {8'd0, s_tdata, 8'd0};
      default: enc_bits = group_bits | {16'd0, s_tdata};
    endcase

    sx7     = char_to_sextet(s_tdata);
    is_pad  = (sx7 == SEXTET_PAD);
    sx6     = is_pad ? 6'd0 : sx7[5:0];
    pad_new = (is_pad && pad_count != PAD_MAX) ? pad_count + 3'd1 : pad_count;
    nbytes  = (pad_new >= 3'd3) ? 2'd0 : 2'(3'd3 - pad_new);
    case (group_count)
      2'd0:    dec_bits = group_bits | {sx6, 18'd0};
      2'd1:    dec_bits = group_bits | {6'd0, sx6, 12'd0};
      2'd2:    dec_bits = group_bits | {12'd0, sx6, 6'd0};
      default: dec_bits = group_bits | {18'd0, sx6};
    endcase
  end

  always_comb begin
    group_bits_next  = group_bits;
    group_count_next = group_count;
    pad_count_next   = pad_count;
    q_push           = 1'b0;
    q_job.kind       = JOB_STAT;
    q_job.bits       = 24'd0;
    q_job.cnt        = 2'd0;
    q_job.last       = s_tlast;
    q_job.status     = 1'b0;

    if (cfg_valid && cfg_ready) begin
      group_bits_next  = 24'd0;
      group_count_next = 2'd0;
      pad_count_next   = 3'd0;
    end else if (accept) begin
      if (direction == DIR_ENCODE) begin
        if (enc_cnt_new == 2'd3 || s_tlast) begin
          q_push           = 1'b1;
          q_job.kind       = JOB_ENC;
          q_job.bits       = enc_bits;
          q_job.cnt        = enc_cnt_new;
          group_bits_next  = 24'd0;
          group_count_next = 2'd0;
          pad_count_next   = 3'd0;
        end else begin
          group_bits_next  = enc_bits;
          group_count_next = enc_cnt_new;
        end
      end else if (group_count != 2'd3) begin
        if (s_tlast) begin
          // message ends inside a group: drop it, flag the length
          q_push           = 1'b1;
          q_job.status     = 1'b1;
          group_bits_next  = 24'd0;
          group_count_next = 2'd0;
          pad_count_next   = 3'd0;
        end else begin
          group_bits_next  = dec_bits;
          group_count_next = group_count + 2'd1;
          pad_count_next   = pad_new;
        end
      end else begin
        if (nbytes != 2'd0) begin
          q_push     = 1'b1;
          q_job.kind = JOB_DEC;
          q_job.bits = dec_bits;
          q_job.cnt  = nbytes;
        end else if (s_tlast) begin
          q_push     = 1'b1;
        end
        group_bits_next  = 24'd0;
        group_count_next = 2'd0;
        pad_count_next   = 3'd0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      direction   <= DIR_ENCODE;
      group_bits  <= 24'd0;
      group_count <= 2'd0;
      pad_count   <= 3'd0;
    end else begin
      if (cfg_valid && cfg_ready) begin
        direction <= cfg_data;
      end
      group_bits  <= group_bits_next;
      group_count <= group_count_next;
      pad_count   <= pad_count_next;
    end
  end

  `ASSERT_NEVER(a_push_when_full, clk, rst, q_push && q_full, "job pushed into full queue")
  `ASSERT_PROP(a_enc_no_full_group, clk, rst,
    (direction == DIR_ENCODE) |-> (group_count != 2'd3), "encoder holds a full group")

endmodule

`default_nettype wire

FILE: hw/rtl/b64c_queue.sv
// ---------------------------------------------------------------------------
// b64c_queue
// Short job queue between the front and back parts.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none
`include "assert_macros.svh"

module b64c_queue (
  input  wire logic            clk,
  input  wire logic            rst,
  input  wire logic            push,
  input  wire b64c_pkg::job_t  push_job,
  output logic                 full,
  input  wire logic            pop,
  output logic                 head_valid,
  output b64c_pkg::job_t       head_job
);
  import b64c_pkg::*;

  job_t              entries [QUEUE_DEPTH];
  logic [QPTR_W-1:0] wr_ptr, rd_ptr;
  logic [QCNT_W-1:0] count;

  assign full       = (count == QCNT_W'(QUEUE_DEPTH));
  assign head_valid = (count != '0);
  assign head_job   = entries[rd_ptr];

  function automatic logic [QPTR_W-1:0] bump(input logic [QPTR_W-1:0] p);
    logic [QPTR_W-1:0] n;
    n = (p == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : p + QPTR_W'(1);
    return n;
  endfunction

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= bump(wr_ptr);
      end
      if (pop) begin
        rd_ptr <= bump(rd_ptr);
      end
      if (push && !pop) begin
        count <= count + QCNT_W'(1);
      end else if (pop && !push) begin
        count <= count - QCNT_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      entries[wr_ptr] <= push_job;
    end
  end

  `ASSERT_NEVER(a_count_range, clk, rst, count > QCNT_W'(QUEUE_DEPTH), "queue count overflow")
  `ASSERT_NEVER(a_pop_empty, clk, rst, pop && !head_valid, "pop from empty queue")

endmodule

`default_nettype wire

FILE: hw/rtl/b64c_back.sv
// ---------------------------------------------------------------------------
// b64c_back
// Expands queued jobs into result transactions, one per cycle unless stalled.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none
`include "assert_macros.svh"

module b64c_back (
  input  wire logic            clk,
  input  wire logic            rst,
  input  wire logic            q_valid,
  input  wire b64c_pkg::job_t  q_job,
  output logic                 q_pop,
  output logic                 m_tvalid,
  input  wire logic            m_tready,
  output logic [7:0]           m_tdata,   // [7:0] out_byte
  output logic                 m_tlast,
  output logic [1:0]           m_tuser    // [0] byte_valid, [1] status
);
  import b64c_pkg::*;

  logic [1:0] idx;
  logic [1:0] final_idx;
  logic       load;
  logic [5:0] sx;
  logic [7:0] item_byte;
  logic       item_bv;

  always_comb begin
    case (idx)
      2'd0:    sx = q_job.bits[23:18];
      2'd1:    sx = q_job.bits[17:12];
      2'd2:    sx = q_job.bits[11:6];
      default: sx = q_job.bits[5:0];
    endcase

    case (q_job.kind)
      JOB_ENC: begin
        final_idx = 2'd3;
        item_bv   = 1'b1;
        item_byte = (idx <= q_job.cnt) ? sextet_to_char(sx) : CHR_PAD;
      end
      JOB_DEC: begin
        final_idx = q_job.cnt - 2'd1;
        item_bv   = 1'b1;
        case (idx)
          2'd0:    item_byte = q_job.bits[23:16];
          2'd1:    item_byte = q_job.bits[15:8];
          default: item_byte = q_job.bits[7:0];
        endcase
      end
      default: begin
        final_idx = 2'd0;
        item_bv   = 1'b0;
        item_byte = 8'd0;
      end
    endcase
  end

  assign load  = q_valid && (!m_tvalid || m_tready);
  assign q_pop = load && (idx == final_idx);

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
      idx      <= 2'd0;
    end else begin
      if (load) begin
        m_tvalid <= 1'b1;
        idx      <= q_pop ? 2'd0 : idx + 2'd1;
      end else if (m_tready) begin
        m_tvalid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      m_tdata <= item_byte;
      m_tlast <= q_job.last && (idx == final_idx);
      m_tuser <= {q_job.status, item_bv};
    end
  end

  `ASSERT_PROP(a_idx_needs_head, clk, rst, (idx != 2'd0) |-> q_valid,
    "job part-sent but queue head gone")
  `ASSERT_PROP(a_status_ends_msg, clk, rst, (m_tvalid && !m_tuser[0]) |-> m_tlast,
    "status-only transaction without last")
  `ASSERT_PROP(a_status_no_data, clk, rst, (m_tvalid && m_tuser[1]) |-> !m_tuser[0],
    "error status on a data transaction")

endmodule

`default_nettype wire

FILE: test/base64url_codec_tb.sv
// ---------------------------------------------------------------------------
// base64url_codec_tb
// Self-checking bench for the base64url codec: a predictor inside a small
// scoreboard turns every accepted input transaction into expected result
// transactions, which are checked in order against the master stream. Both
// stream sides idle at random; the sink also holds off for a long stretch
// once to back the job queue up into the input.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module base64url_codec_tb;
  import b64c_pkg::*;

  localparam logic STAT_OK    = 1'b0;
  localparam logic STAT_SHORT = 1'b1;  // decode message ended inside a group
  localparam int   CYCLE_LIMIT = 200000;
  localparam int   SETTLE      = 10;
  localparam int   HOLD_CYCLES = 80;
  localparam int   HOLD_AFTER  = 60;   // input transactions before the long hold

  typedef struct packed {
    logic [7:0] data;
    logic       valid;
    logic       last;
    logic       status;
  } codec_result_t;

  class codec_scoreboard;
    logic          dir;
    logic [23:0]   acc;
    int unsigned   fill;
    int unsigned   pads;
    logic [7:0]    glyph [64];
    logic [5:0]    sextet_of [256];
    codec_result_t expected_q [$];
    int unsigned   n_in, n_enc, n_dec, n_out, n_bad;

    function new();
      int i;
      for (i = 0; i < 26; i++) begin
        glyph[i]      = CHR_UPPER_A + 8'(i);
        glyph[i + 26] = CHR_LOWER_A + 8'(i);
      end
      for (i = 0; i < 10; i++) glyph[i + 52] = CHR_DIGIT_0 + 8'(i);
      glyph[62] = CHR_DASH;
      glyph[63] = CHR_USCORE;
      // anything outside the alphabet reads as sextet zero
      for (i = 0; i < 256; i++) sextet_of[i] = 6'd0;
      for (i = 0; i < 64; i++) sextet_of[glyph[i]] = 6'(i);
      dir = DIR_ENCODE;
      clear_group();
    endfunction

    function void clear_group();
      acc  = 24'd0;
      fill = 0;
      pads = 0;
    endfunction

    function void set_direction(logic d);
      dir = d;
      clear_group();
    endfunction

    function void push(logic [7:0] d, logic v, logic l, logic s);
      codec_result_t r;
      r.data   = d;
      r.valid  = v;
      r.last   = l;
      r.status = s;
      expected_q.push_back(r);
    endfunction

    function int unsigned pending();
      return expected_q.size();
    endfunction

    function void note_input(logic [7:0] b, logic last);
      int unsigned slot;
      int unsigned nbytes;
      logic [5:0]  sx;
      int          i;
      n_in++;
      if (dir == DIR_ENCODE) begin
        n_enc++;
        slot = (fill > 2) ? 2 : fill;
        acc  = acc | (24'(b) << (16 - 8 * slot));
        slot++;
        if (slot < 3 && !last) begin
          fill = slot;
          return;
        end
        for (i = 0; i < 4; i++) begin
          sx = acc[23 - 6 * i -: 6];
          push((i <= slot) ? glyph[sx] : CHR_PAD, 1'b1, (i == 3) ? last : 1'b0, STAT_OK);
        end
        clear_group();
      end else begin
        n_dec++;
        if (b == CHR_PAD) begin
          sx = 6'd0;
          if (pads < 7) pads++;
        end else begin
          sx = sextet_of[b];
        end
        acc = acc | (24'(sx) << (18 - 6 * fill));
        if (fill < 3) begin
          fill++;
          if (last) begin
            clear_group();
            push(8'h00, 1'b0, 1'b1, STAT_SHORT);
          end
          return;
        end
        nbytes = (pads >= 3) ? 0 : 3 - pads;
        for (i = 0; i < nbytes; i++)
          push(acc[23 - 8 * i -: 8], 1'b1, last && (i + 1 == nbytes), STAT_OK);
        clear_group();
        if (last && nbytes == 0) push(8'h00, 1'b0, 1'b1, STAT_OK);
      end
    endfunction

    function void check_result(logic [7:0] d, logic v, logic l, logic s);
      codec_result_t e;
      n_out++;
      if (expected_q.size() == 0) begin
        n_bad++;
        if (n_bad <= 10)
          $display("unexpected result: data %02h valid %0b last %0b status %0b", d, v, l, s);
        return;
      end
      e = expected_q.pop_front();
      if (e.data !== d || e.valid !== v || e.last !== l || e.status !== s) begin
        n_bad++;
        if (n_bad <= 10)
          $display("mismatch at result %0d: expected %02h/%0b/%0b/%0b, got %02h/%0b/%0b/%0b",
                   n_out, e.data, e.valid, e.last, e.status, d, v, l, s);
      end
    endfunction
  endclass

  logic       clk = 1'b0;
  logic       rst;
  logic       s_tvalid;
  logic       s_tready;
  logic [7:0] s_tdata;   // [7:0] in_byte
  logic       s_tlast;   // in_last
  logic       m_tvalid;
  logic       m_tready;
  logic [7:0] m_tdata;   // [7:0] out_byte
  logic       m_tlast;   // out_last
  logic [1:0] m_tuser;   // [0] byte_valid, [1] status
  logic       cfg_valid;
  logic       cfg_ready;
  logic       cfg_data;

  codec_scoreboard sb = new();
  logic        calm;
  logic        held;
  int unsigned hold_left;
  int unsigned cycles;

  base64url_codec dut (
    .clk       (clk),
    .rst       (rst),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .s_tdata   (s_tdata),
    .s_tlast   (s_tlast),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata),
    .m_tlast   (m_tlast),
    .m_tuser   (m_tuser),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_data  (cfg_data)
  );

  always #2 clk = ~clk;

  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d results outstanding", cycles, sb.pending());
      $display("Some tests failed");
      $finish;
    end
  end

  // sink: random back-pressure plus one long hold once traffic is flowing
  always @(negedge clk) begin
    if (!rst && !held && sb.n_in >= HOLD_AFTER) begin
      held = 1'b1;
      hold_left = HOLD_CYCLES;
    end
    if (hold_left > 0) begin
      hold_left--;
      m_tready <= 1'b0;
    end else begin
      m_tready <= calm || ($urandom_range(0, 99) >= 25);
    end
  end

  always @(posedge clk) begin
    if (!rst && m_tvalid && m_tready)
      sb.check_result(m_tdata, m_tuser[0], m_tlast, m_tuser[1]);
  end

  task automatic send_item(input logic [7:0] b, input logic last);
    while (!calm && $urandom_range(0, 99) < 25) begin
      s_tvalid <= 1'b0;
      @(negedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata  <= b;
    s_tlast  <= last;
    do @(posedge clk); while (!s_tready);
    sb.note_input(b, last);
    @(negedge clk);
  endtask

  task automatic send_text(input string txt, input logic close_msg);
    int i;
    for (i = 0; i < txt.len(); i++) send_item(txt[i], close_msg && (i == txt.len() - 1));
  endtask

  // drain the pipeline: wait until every expected result is checked, then settle
  task automatic drain();
    s_tvalid <= 1'b0;
    while (sb.pending() != 0) @(negedge clk);
    repeat (SETTLE) @(negedge clk);
  endtask

  task automatic write_direction(input logic d);
    cfg_valid <= 1'b1;
    cfg_data  <= d;
    do @(posedge clk); while (!cfg_ready);
    sb.set_direction(d);
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  task automatic random_encode(input int unsigned target);
    int unsigned sent;
    int unsigned len;
    int unsigned k;
    sent = 0;
    while (sent < target) begin
      len = $urandom_range(1, 10);
      // now and then a message runs on without a closing transaction
      for (k = 0; k < len; k++)
        send_item(8'($urandom_range(0, 255)), (k == len - 1) && ($urandom_range(0, 9) != 0));
      sent += len;
    end
  endtask

  task automatic random_decode(input int unsigned target);
    int unsigned sent;
    int unsigned groups;
    int unsigned tail_pads;
    int unsigned len;
    int unsigned g;
    int unsigned p;
    logic [7:0]  c;
    sent = 0;
    while (sent < target) begin
      if ($urandom_range(0, 99) < 80) begin
        groups    = $urandom_range(1, 3);
        tail_pads = $urandom_range(0, 2);
        for (g = 0; g < groups; g++) begin
          for (p = 0; p < 4; p++) begin
            if (g == groups - 1 && p >= 4 - tail_pads) c = CHR_PAD;
            else if ($urandom_range(0, 19) == 0) c = CHR_PAD;
            else c = sb.glyph[$urandom_range(0, 63)];
            send_item(c, (g == groups - 1) && (p == 3));
          end
        end
        sent += 4 * groups;
      end else begin
        // noise: arbitrary bytes, often ending mid-group
        len = $urandom_range(1, 6);
        for (p = 0; p < len; p++) send_item(8'($urandom_range(0, 255)), p == len - 1);
        sent += len;
      end
    end
  endtask

  initial begin
    rst       = 1'b1;
    s_tvalid  = 1'b0;
    s_tdata   = 8'h00;
    s_tlast   = 1'b0;
    m_tready  = 1'b0;
    cfg_valid = 1'b0;
    cfg_data  = DIR_ENCODE;
    calm      = 1'b0;
    held      = 1'b0;
    hold_left = 0;
    cycles    = 0;
    repeat (5) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    write_direction(DIR_ENCODE);
    send_item(8'h00, 1'b1);                  // one byte, two pads
    send_item(8'hff, 1'b0);
    send_item(8'hff, 1'b1);                  // two bytes, one pad
    send_item(8'hfb, 1'b0);                  // full group giving '-' and '_'
    send_item(8'hff, 1'b0);
    send_item(8'hbf, 1'b0);
    send_item(8'h80, 1'b1);
    send_item(8'h12, 1'b0);                  // left gathering across the write
    drain();

    write_direction(DIR_DECODE);
    send_text("-_-_09az", 1'b1);
    send_text("A===", 1'b1);                 // three pads: no bytes, status-only
    send_text("~=\377=", 1'b1);              // unknown chars and a pad inside the group
    send_text("ZB", 1'b1);                   // short final group
    send_text("x", 1'b0);
    drain();
    write_direction(DIR_DECODE);             // rewrite drops the partial group

    random_decode(65);
    drain();
    write_direction(DIR_ENCODE);
    random_encode(60);
    drain();
    write_direction(DIR_DECODE);
    calm = 1'b1;
    random_decode(60);
    drain();
    calm = 1'b0;
    write_direction(DIR_ENCODE);
    random_encode(60);
    drain();

    sb.n_bad += sb.pending();
    $display("Covered %0d input transactions (%0d encode, %0d decode) over several direction",
             sb.n_in, sb.n_enc, sb.n_dec);
    $display("settings, checking %0d result transactions with %0d errors", sb.n_out, sb.n_bad);
    if (sb.n_bad == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule
